// ===== rtl/core/iq_correct_overlap_framer_assert.svh =====
// Assertion macros used by the port-level checker.
// No dependencies; include by bare file name inside a module body.
`ifndef IQ_CORRECT_OVERLAP_FRAMER_ASSERT_SVH
`define IQ_CORRECT_OVERLAP_FRAMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IQCOF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iqcof assertion failed");

// next-cycle implication
`define IQCOF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iqcof assertion failed");

`endif

// ===== rtl/core/iqcof_pkg.sv =====
// Shared constants, types and register codes for the I/Q correction framer.
// No dependencies.
package iqcof_pkg;

    localparam int HALF_DEPTH   = 1024;
    localparam int SLOT_W       = $clog2(HALF_DEPTH);
    localparam int DEPTH_W      = $clog2(HALF_DEPTH + 1);
    localparam int SAMPLE_W     = 32;
    localparam int COEF_W       = 16;
    localparam int FRAC_W       = 14;
    localparam int HALF_SIZE_W  = 11;
    localparam int SLOT_FIELD_W = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int PAIR_W       = 2 * SAMPLE_W;

    localparam logic signed [COEF_W-1:0] UNITY_GAIN = COEF_W'(1 << FRAC_W);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_24BIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_SIDEBAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSMIT_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE      = 3'd5;

    typedef struct packed {
        logic                     format_24bit;
        logic signed [COEF_W-1:0] gain;
        logic signed [COEF_W-1:0] phase;
        logic                     upper_sideband;
        logic                     transmit_mode;
    } corr_cfg_t;

    // codec word to signed sample
    function automatic logic signed [SAMPLE_W-1:0] unpack_word(
        input logic [SAMPLE_W-1:0] w,
        input logic                fmt24
    );
        if (fmt24)
        begin
            unpack_word = {{8{w[15]}}, w[15:0], w[31:24]};
        end
        else
        begin
            unpack_word = {w[15:0], w[31:16]};
        end
    endfunction

endpackage

// ===== rtl/core/iqcof_if.sv =====
// Valid/ready channel interfaces for raw sample beats and framed result beats.
// Depends on iqcof_pkg.
interface iqcof_in_if;
    logic                            valid;
    logic                            ready;
    logic [iqcof_pkg::SAMPLE_W-1:0]  raw_i;
    logic [iqcof_pkg::SAMPLE_W-1:0]  raw_q;

    modport source (output valid, output raw_i, output raw_q, input ready);
    modport sink   (input valid, input raw_i, input raw_q, output ready);
endinterface

interface iqcof_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [iqcof_pkg::SLOT_FIELD_W-1:0]     slot;
    logic signed [iqcof_pkg::SAMPLE_W-1:0]  old_i;
    logic signed [iqcof_pkg::SAMPLE_W-1:0]  old_q;
    logic signed [iqcof_pkg::SAMPLE_W-1:0]  new_i;
    logic signed [iqcof_pkg::SAMPLE_W-1:0]  new_q;
    logic                                   frame_done;

    modport source (output valid, output slot, output old_i, output old_q,
                    output new_i, output new_q, output frame_done, input ready);
    modport sink   (input valid, input slot, input old_i, input old_q,
                    input new_i, input new_q, input frame_done, output ready);
endinterface

// ===== rtl/core/iq_correct_overlap_framer.sv =====
// Top level of the I/Q correction and half-overlap FFT framer.
// Depends on iqcof_pkg, iqcof_if, iqcof_ram and iqcof_correct.
//
// Raw codec word pairs come in on samples, one beat per clock when the output side keeps
// up; each accepted beat crosses the s1, s2 and output registers (accept, multiply,
// round and saturate) to frames. The rate is set by the history store, a single RAM with
// one read port and one write port: the old pair at the slot is read on the accept cycle
// and the corrected pair is written back from s2, so each beat costs one read and one
// write and beats follow back to back. Pairs still in flight that target the same slot
// (a half frame shorter than the pipeline) are forwarded around the RAM. The store reads
// as zero after reset with no clearing pass: a fill mark records how far the slot counter
// has ever reached, and slots at or past it read as zero. Configuration is written
// through cfg_we/cfg_index/cfg_data and must only change while no beat is in flight.
module iq_correct_overlap_framer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [iqcof_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iqcof_pkg::CFG_DATA_W-1:0]    cfg_data,
    iqcof_in_if.sink                            samples,
    iqcof_out_if.source                         frames
);
    import iqcof_pkg::*;

    localparam int CMP_W = (DEPTH_W > HALF_SIZE_W) ? DEPTH_W : HALF_SIZE_W;

    // configuration registers
    corr_cfg_t              cfg_reg;
    logic [HALF_SIZE_W-1:0] half_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format_24bit   <= 1'b1;
            cfg_reg.gain           <= UNITY_GAIN;
            cfg_reg.phase          <= '0;
            cfg_reg.upper_sideband <= 1'b0;
            cfg_reg.transmit_mode  <= 1'b0;
            half_size_reg          <= HALF_SIZE_W'(512);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT_24BIT:   cfg_reg.format_24bit   <= cfg_data[0];
                REG_GAIN:           cfg_reg.gain           <= cfg_data;
                REG_PHASE:          cfg_reg.phase          <= cfg_data;
                REG_UPPER_SIDEBAND: cfg_reg.upper_sideband <= cfg_data[0];
                REG_TRANSMIT_MODE:  cfg_reg.transmit_mode  <= cfg_data[0];
                REG_HALF_SIZE:      half_size_reg          <= cfg_data[HALF_SIZE_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // pipeline control: every stage moves together when the output can take a beat
    logic adv, acc_beat, wr_en;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;

    assign adv           = !out_valid_reg || frames.ready;
    assign acc_beat      = samples.valid && adv;
    assign samples.ready = adv;
    assign wr_en         = adv && s2_valid_reg;

    // slot counter and fill mark
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;
    logic [DEPTH_W-1:0] fill_reg, fill_next;
    logic [CMP_W-1:0]   hs_ext, eff, idx_plus;
    logic               last, unwritten;

    always_comb
    begin
        hs_ext = CMP_W'(half_size_reg);
        if (hs_ext == '0)
        begin
            eff = CMP_W'(1);
        end
        else if (hs_ext > CMP_W'(HALF_DEPTH))
        begin
            eff = CMP_W'(HALF_DEPTH);
        end
        else
        begin
            eff = hs_ext;
        end
        idx_plus  = CMP_W'(cnt_reg) + CMP_W'(1);
        last      = (idx_plus >= eff);
        unwritten = !(DEPTH_W'(cnt_reg) < fill_reg);
        cnt_next  = last ? '0 : cnt_reg + SLOT_W'(1);
        fill_next = unwritten ? fill_reg + DEPTH_W'(1) : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            fill_reg <= '0;
        end
        else if (acc_beat)
        begin
            cnt_reg  <= cnt_next;
            fill_reg <= fill_next;
        end
    end

    // correction datapath, aligned with s1/s2
    logic signed [SAMPLE_W-1:0] corr_i, corr_q;

    iqcof_correct u_correct (
        .clk   (clk),
        .adv   (adv),
        .cfg   (cfg_reg),
        .raw_i (samples.raw_i),
        .raw_q (samples.raw_q),
        .new_i (corr_i),
        .new_q (corr_q)
    );

    // history store
    logic [SLOT_W-1:0] s1_idx_reg, s2_idx_reg;
    logic [PAIR_W-1:0] rd_data, wr_data;

    assign wr_data = {corr_i, corr_q};

    iqcof_ram #(
        .DEPTH (HALF_DEPTH),
        .WIDTH (PAIR_W)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_idx_reg),
        .wdata (wr_data),
        .re    (adv),
        .raddr (cnt_reg),
        .rdata (rd_data)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= acc_beat;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // s1: slot info, plus the write that landed on the read edge (RAM gave old data)
    logic              s1_last_reg, s1_zero_reg, s1_col_reg;
    logic [PAIR_W-1:0] s1_col_data_reg;
    logic              s2_last_reg;
    logic [PAIR_W-1:0] s2_old_reg, old_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg      <= cnt_reg;
            s1_last_reg     <= last;
            s1_zero_reg     <= unwritten;
            s1_col_reg      <= wr_en && (s2_idx_reg == cnt_reg);
            s1_col_data_reg <= wr_data;
        end
    end

    // old pair: never written reads zero, then youngest in-flight write wins
    always_comb
    begin
        if (s1_zero_reg)
        begin
            old_next = '0;
        end
        else if (s2_valid_reg && (s2_idx_reg == s1_idx_reg))
        begin
            old_next = wr_data;
        end
        else if (s1_col_reg)
        begin
            old_next = s1_col_data_reg;
        end
        else
        begin
            old_next = rd_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;
            s2_old_reg  <= old_next;
        end
    end

    // output register
    logic [SLOT_FIELD_W-1:0]    slot_reg;
    logic signed [SAMPLE_W-1:0] old_i_reg, old_q_reg, new_i_reg, new_q_reg;
    logic                       done_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slot_reg  <= SLOT_FIELD_W'(s2_idx_reg);
            old_i_reg <= s2_old_reg[PAIR_W-1:SAMPLE_W];
            old_q_reg <= s2_old_reg[SAMPLE_W-1:0];
            new_i_reg <= corr_i;
            new_q_reg <= corr_q;
            done_reg  <= s2_last_reg;
        end
    end

    assign frames.valid      = out_valid_reg;
    assign frames.slot       = slot_reg;
    assign frames.old_i      = old_i_reg;
    assign frames.old_q      = old_q_reg;
    assign frames.new_i      = new_i_reg;
    assign frames.new_q      = new_q_reg;
    assign frames.frame_done = done_reg;
endmodule

// ===== rtl/core/iqcof_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module iqcof_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/iqcof_correct.sv =====
// Unpack and gain/phase correction datapath, two register stages plus output logic.
// Depends on iqcof_pkg.
module iqcof_correct (
    input  logic                                  clk,
    input  logic                                  adv,
    input  iqcof_pkg::corr_cfg_t                  cfg,
    input  logic [iqcof_pkg::SAMPLE_W-1:0]        raw_i,
    input  logic [iqcof_pkg::SAMPLE_W-1:0]        raw_q,
    output logic signed [iqcof_pkg::SAMPLE_W-1:0] new_i,
    output logic signed [iqcof_pkg::SAMPLE_W-1:0] new_q
);
    import iqcof_pkg::*;

    logic signed [SAMPLE_W-1:0] si_reg, sq_reg;
    logic signed [COEF_W-1:0]   g_reg, p_reg;
    logic signed [PROD_W-1:0]   pi_reg, pq_reg;
    logic signed [SAMPLE_W-1:0] nq_reg;
    logic signed [PROD_W-1:0]   pi_next, pq_next;
    logic signed [SAMPLE_W-1:0] nq_next;
    logic signed [ACC_W-1:0]    acc;
    logic [ACC_W-FRAC_W-SAMPLE_W:0] top_bits;

    // stage 1: unpack, pick coefficients
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            si_reg <= unpack_word(raw_i, cfg.format_24bit);
            sq_reg <= unpack_word(raw_q, cfg.format_24bit);
            g_reg  <= cfg.transmit_mode ? UNITY_GAIN : cfg.gain;
            p_reg  <= cfg.transmit_mode ? '0 : cfg.phase;
        end
    end

    // stage 2: products and sideband negate
    always_comb
    begin
        pi_next = si_reg * g_reg;
        pq_next = sq_reg * p_reg;
        if (!cfg.upper_sideband)
        begin
            nq_next = sq_reg;
        end
        else if (sq_reg == SAMPLE_MIN)
        begin
            nq_next = SAMPLE_MAX;
        end
        else
        begin
            nq_next = -sq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pi_reg <= pi_next;
            pq_reg <= pq_next;
            nq_reg <= nq_next;
        end
    end

    // round half up, floor shift, saturate
    always_comb
    begin
        acc      = {pi_reg[PROD_W-1], pi_reg} + {pq_reg[PROD_W-1], pq_reg}
                 + ACC_W'(1 << (FRAC_W - 1));
        top_bits = acc[ACC_W-1:FRAC_W+SAMPLE_W-1];
        if ((top_bits == '0) || (top_bits == '1))
        begin
            new_i = acc[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
        else if (acc[ACC_W-1])
        begin
            new_i = SAMPLE_MIN;
        end
        else
        begin
            new_i = SAMPLE_MAX;
        end
        new_q = nq_reg;
    end
endmodule

// ===== rtl/core/iqcof_checker.sv =====
// Port-level checker for the framer and the bind that attaches it.
// Depends on iqcof_pkg and iq_correct_overlap_framer_assert.svh.
module iqcof_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [iqcof_pkg::SLOT_FIELD_W-1:0]  slot,
    input logic                                frame_done
);
    import iqcof_pkg::*;

    `include "iq_correct_overlap_framer_assert.svh"

    logic                    in_fire, out_fire;
    logic [2:0]              pending_reg;
    logic [SLOT_FIELD_W-1:0] prev_slot_reg;
    logic                    prev_done_reg, have_prev_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            prev_slot_reg <= '0;
            prev_done_reg <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_fire) - 3'(out_fire);
            if (out_fire)
            begin
                prev_slot_reg <= slot;
                prev_done_reg <= frame_done;
                have_prev_reg <= 1'b1;
            end
        end
    end

    // a stalled result beat stays offered
    `IQCOF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // no result beat without an accepted sample
    `IQCOF_ASSERT_NOW(a_no_invent, out_fire, pending_reg != 3'd0)
    // frame boundary restarts at slot zero
    `IQCOF_ASSERT_NOW(a_wrap, out_fire && have_prev_reg && prev_done_reg, slot == '0)
    // within a frame slots advance by one
    `IQCOF_ASSERT_NOW(a_step, out_fire && have_prev_reg && !prev_done_reg,
                      slot == SLOT_FIELD_W'(prev_slot_reg + SLOT_FIELD_W'(1)))
endmodule

bind iq_correct_overlap_framer iqcof_checker u_iqcof_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (frames.valid),
    .out_ready  (frames.ready),
    .slot       (frames.slot),
    .frame_done (frames.frame_done)
);
